FILE: hdl/bit_plane_run_length_encoder_macros.svh
// assertion macros for the bit-plane run-length encoder checker
`ifndef BIT_PLANE_RUN_LENGTH_ENCODER_MACROS_SVH
`define BIT_PLANE_RUN_LENGTH_ENCODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define BPRE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BPRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bpre_pkg.sv
// shared types and constants for the bit-plane run-length encoder
package bpre_pkg;

  localparam int PLANES_DEF     = 8;
  localparam int SLOTS_PER_LANE = 3;
  localparam int SAMPLE_W       = 8;
  localparam int COUNT_W        = 8;
  localparam logic [COUNT_W-1:0] RUN_MAX = 8'd255;

  // one token slot produced by a lane
  typedef struct packed {
    logic               vld;
    logic [2:0]         plane;
    logic [COUNT_W-1:0] val;
    logic               start;
  } slot_t;

endpackage

FILE: hdl/bit_plane_run_length_encoder.sv
// top level of the bit-plane run-length encoder
// one 8-bit sample per word is split into PLANES bit planes, each coded by its own lane
// (current bit and 8-bit run count); the lanes' tokens for a word are loaded into a
// pending buffer and sent out one per cycle while out_ready is high, in plane order,
// start bit first, then run counts, with last_of_run marking the final token of the
// word. the first token of a word shows on the output the cycle after the word is
// taken. each token is held until accepted; the next sample is taken in the cycle
// its predecessor's last token leaves (in_ready follows out_ready in that cycle), so
// with the receiver ready, words with at most one token (the usual case) go through
// at one per cycle and words with none are taken back to back. the rate is set by the
// number of tokens each word gives and by how often the receiver is ready
module bit_plane_run_length_encoder #(
  parameter int PLANES = bpre_pkg::PLANES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpre_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_first_of_pass,
  input  logic                          in_last_of_pass,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_plane,
  output logic [bpre_pkg::COUNT_W-1:0]  out_token,
  output logic                          out_is_start,
  output logic                          out_last_of_run
);

  localparam int NSLOT = PLANES * bpre_pkg::SLOTS_PER_LANE;

  logic                         in_fire;
  bpre_pkg::slot_t [NSLOT-1:0]  all_slots;
  bpre_pkg::slot_t              sel;

  // lane state moves only when a word is taken
  assign in_fire = in_valid && in_ready;

  // one lane per bit plane, slots packed lowest plane first
  for (genvar p = 0; p < PLANES; p++) begin : g_lane
    bpre_lane #(
      .PLANE_IDX (p)
    ) u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .load          (in_fire),
      .sample        (in_sample),
      .first_of_pass (in_first_of_pass),
      .last_of_pass  (in_last_of_pass),
      .slots         (all_slots[bpre_pkg::SLOTS_PER_LANE*p +: bpre_pkg::SLOTS_PER_LANE])
    );
  end

  // merging stage serialises the word's tokens
  bpre_merge #(
    .NSLOT (NSLOT)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .slots_in  (all_slots),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sel       (sel),
    .sel_last  (out_last_of_run)
  );

  assign out_plane    = sel.plane;
  assign out_token    = sel.val;
  assign out_is_start = sel.start;

endmodule

FILE: hdl/bpre_lane.sv
// one bit-plane lane: run state and up to three tokens per word
module bpre_lane #(
  parameter int PLANE_IDX = 0
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  logic [bpre_pkg::SAMPLE_W-1:0]           sample,
  input  logic                                   first_of_pass,
  input  logic                                   last_of_pass,
  output bpre_pkg::slot_t [bpre_pkg::SLOTS_PER_LANE-1:0] slots
);

  localparam logic [2:0] BIT_SEL = 3'(PLANE_IDX % 8);

  logic                          bit_r, bit_nxt;
  logic [bpre_pkg::COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic                          bit_in;
  logic                          base_bit;
  logic [bpre_pkg::COUNT_W-1:0]  base_cnt;
  logic [bpre_pkg::COUNT_W-1:0]  cnt_pre;
  logic                          chg;
  logic                          wrap;

  assign bit_in = (PLANE_IDX < 8) ? sample[BIT_SEL] : 1'b0;

  always_comb begin
    base_bit = first_of_pass ? bit_in : bit_r;
    base_cnt = first_of_pass ? '0 : cnt_r;
    chg      = !first_of_pass && (bit_in != bit_r);
    wrap     = !chg && (base_cnt == bpre_pkg::RUN_MAX);
    cnt_pre  = (chg || wrap) ? '0 : base_cnt;
    cnt_nxt  = cnt_pre + 8'd1;
    bit_nxt  = chg ? bit_in : base_bit;
  end

  always_comb begin
    // slot a: start bit, changed-run count or saturated run
    slots[0].vld   = first_of_pass || chg || wrap;
    slots[0].plane = 3'(PLANE_IDX % 8);
    slots[0].start = first_of_pass;
    slots[0].val   = first_of_pass ? {7'd0, bit_in} : (wrap ? bpre_pkg::RUN_MAX : cnt_r);
    // slot b: zero-length run after saturation
    slots[1].vld   = wrap;
    slots[1].plane = 3'(PLANE_IDX % 8);
    slots[1].start = 1'b0;
    slots[1].val   = '0;
    // slot c: flush on last word
    slots[2].vld   = last_of_pass;
    slots[2].plane = 3'(PLANE_IDX % 8);
    slots[2].start = 1'b0;
    slots[2].val   = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
      cnt_r <= '0;
    end else if (load) begin
      bit_r <= bit_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/bpre_merge.sv
// merging stage: holds one word's tokens and sends them out lowest slot first
module bpre_merge #(
  parameter int NSLOT = bpre_pkg::PLANES_DEF * bpre_pkg::SLOTS_PER_LANE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  bpre_pkg::slot_t [NSLOT-1:0]   slots_in,
  output logic                          can_load,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bpre_pkg::slot_t               sel,
  output logic                          sel_last
);

  logic [NSLOT-1:0]            mask_r, mask_nxt;
  bpre_pkg::slot_t [NSLOT-1:0] pend_r;
  logic [NSLOT-1:0]            low;
  logic [NSLOT-1:0]            rest;
  logic [NSLOT-1:0]            new_mask;

  assign low      = mask_r & (~mask_r + NSLOT'(1));
  assign rest     = mask_r & ~low;
  assign out_valid = |mask_r;
  assign sel_last  = ~|rest;
  assign can_load  = ~|mask_r || (out_ready && ~|rest);

  always_comb begin
    sel = '0;
    for (int k = 0; k < NSLOT; k++) begin
      new_mask[k] = slots_in[k].vld;
      if (low[k]) sel = sel | pend_r[k];
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (load) mask_nxt = new_mask;
    else if (out_valid && out_ready) mask_nxt = rest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mask_r <= '0;
    else        mask_r <= mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) pend_r <= slots_in;
  end

endmodule

FILE: hdl/bpre_checker.sv
// port-level checker for the bit-plane run-length encoder, bound to the top level
`include "bit_plane_run_length_encoder_macros.svh"

module bpre_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_first_of_pass,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_plane,
  input logic [7:0] out_token,
  input logic       out_is_start,
  input logic       out_last_of_run
);

  // a stalled token holds
  `BPRE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_token) && $stable(out_plane) && $stable(out_last_of_run), "stalled token changed")

  // start tokens only carry a single bit
  `BPRE_ASSERT_NOW(a_start_bit, out_valid && out_is_start, out_token[7:1] == 7'd0, "start token above one")

  // a first word always yields start tokens
  `BPRE_ASSERT_NEXT(a_first_tokens, in_valid && in_ready && in_first_of_pass, out_valid && out_is_start, "first word gave no start token")

  // no new word while more than one token of the current word waits
  `BPRE_ASSERT_NOW(a_no_overrun, out_valid && !out_last_of_run, !in_ready, "word taken over pending tokens")

endmodule

bind bit_plane_run_length_encoder bpre_checker u_bpre_checker (.*);
